// File: rtl/core/stsg_pkg.sv
// ----------------------------------------------------------------------------
// stsg_pkg: shared definitions for the sine tone sample generator
// Register indexes, default sizes and the quarter-wave table entry function.
// ----------------------------------------------------------------------------
package stsg_pkg;

   // default sizes, handed to the top level as parameter defaults
   localparam int SINE_TABLE_BITS_DEF  = 10;
   localparam int MAX_CHANNELS_DEF     = 8;
   localparam int MAX_SAMPLE_BYTES_DEF = 4;

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_PHASE_INC     = csr_idx_type'(0);
   localparam csr_idx_type REG_TONE_ENABLE   = csr_idx_type'(1);
   localparam csr_idx_type REG_SAMPLE_BYTES  = csr_idx_type'(2);
   localparam csr_idx_type REG_CHANNEL_COUNT = csr_idx_type'(3);

   // register reset values
   localparam logic [2:0] SAMPLE_BYTES_RST  = 3'd2;
   localparam logic [3:0] CHANNEL_COUNT_RST = 4'd1;

   // pi/2 in unsigned Q1.31
   localparam logic [63:0] HALF_PI_Q31 = 64'hC90F_DAA2;
   localparam int          TAYLOR_TERMS = 9;

   // Unsigned quotient by restoring long division; the divisor is never zero.
   // Used only while the constant table is built.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Quarter-wave entry k: sin(pi/2 * k / 2^table_bits) in Q1.31, built by
   // a truncating Taylor series and capped at full scale. Used only to
   // build the constant table at elaboration.
   function automatic logic [31:0] sine_q31(input logic [31:0] k, input int table_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] n;
      x    = (HALF_PI_Q31 * {32'b0, k}) >> table_bits;
      x2   = (x * x) >> 31;
      term = x;
      sum  = x;
      n    = 64'd1;
      for (int i = 0; i < TAYLOR_TERMS; i++) begin
         term = udiv64((term * x2) >> 31, (n + 64'd1) * (n + 64'd2));
         n    = n + 64'd2;
         if (i[0]) begin
            sum = sum + term;
         end else begin
            sum = sum - term;
         end
      end
      if (sum > 64'h7FFF_FFFF) begin
         sum = 64'h7FFF_FFFF;
      end
      return sum[31:0];
   endfunction

endpackage

// File: rtl/core/sine_tone_sample_generator_unit.sv
// ----------------------------------------------------------------------------
// sine_tone_sample_generator_unit: phase-accumulator sine tone generator
// Each request beat (one sample tick) yields one PCM frame of little-endian
// bytes, the same sample copied to every channel in order.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat per sample tick; req_restart_phase clears the
//   phase before this tick's sample is taken.
//   rsp_ channel: one beat per byte, channel by channel, least significant
//   byte first; rsp_last_byte marks the final byte of the frame.
//   csr_ channel: register writes by index (phase increment, tone enable,
//   sample bytes, channel count); csr_ready is always high. Write only
//   while no frame is in flight.
// Pipeline: a request beat loads the sine table read register; the sample
//   register loads from it once the previous frame has drained.
// Throughput: one byte per cycle unless the receiver stalls, channel_count *
//   sample_bytes bytes per frame on the single byte-wide response port; the
//   next request is taken while a frame drains, so frames follow without gaps.
// Stall: while the receiver stalls, the current byte holds; req_stall rises
//   while the table read stage is full and the current frame is not done.
// Reset: phase and pipeline cleared, registers to defaults (increment 0,
//   tone off, two bytes, one channel). The sine table is a constant ROM and
//   needs no fill pass.
// ----------------------------------------------------------------------------
module sine_tone_sample_generator_unit #(
   parameter int SINE_TABLE_BITS  = stsg_pkg::SINE_TABLE_BITS_DEF,
   parameter int MAX_CHANNELS     = stsg_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_SAMPLE_BYTES = stsg_pkg::MAX_SAMPLE_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_restart_phase,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic [2:0]                      rsp_channel_index,
   output logic [1:0]                      rsp_byte_index,
   output logic                            rsp_last_byte,
   // configuration channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [stsg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stsg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import stsg_pkg::*;

   localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;
   localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int NC_W       = $clog2(MAX_CHANNELS + 1);

   typedef logic [31:0] rom_type [TABLE_SIZE];

   // build the quarter-wave table at elaboration
   function automatic rom_type build_rom();
      rom_type t;
      for (int k = 0; k < TABLE_SIZE; k++) begin
         t[k] = sine_q31(32'(k), SINE_TABLE_BITS);
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // configuration registers
   logic [31:0]     phase_inc_ff;
   logic            tone_en_ff;
   logic [2:0]      sample_bytes_ff;
   logic [3:0]      channel_count_ff;

   // phase accumulator
   logic [31:0]     phase_ff, phase_in;
   logic [31:0]     phase_used;

   // table read stage
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_neg_ff;
   logic            s1_full_ff;
   logic [31:0]     rom_q_ff;

   // frame serializer
   logic            frame_valid_ff, frame_valid_in;
   logic [31:0]     sample_ff;
   logic [1:0]      byte_cnt_ff, byte_cnt_in;
   logic [CH_W-1:0] ch_cnt_ff, ch_cnt_in;

   logic            req_beat, rsp_beat;
   logic            last_b, last_ch, frame_done, s1_advance;
   logic [2:0]      nb_eff;
   logic [NC_W-1:0] nc_eff;
   logic [1:0]                   quad;
   logic [SINE_TABLE_BITS-1:0]   pos;
   logic [SINE_TABLE_BITS:0]     rom_idx;
   logic [5:0]      shamt;
   logic [63:0]     prod;
   logic [31:0]     amp, mag, sample_new;

   // clamp sizes to their legal ranges
   always_comb begin
      if (sample_bytes_ff == 3'd0) begin
         nb_eff = 3'd1;
      end else if (32'(sample_bytes_ff) > MAX_SAMPLE_BYTES) begin
         nb_eff = 3'(MAX_SAMPLE_BYTES);
      end else begin
         nb_eff = sample_bytes_ff;
      end
      if (channel_count_ff == 4'd0) begin
         nc_eff = NC_W'(1);
      end else if (32'(channel_count_ff) > MAX_CHANNELS) begin
         nc_eff = NC_W'(MAX_CHANNELS);
      end else begin
         nc_eff = NC_W'(channel_count_ff);
      end
   end

   // handshakes
   assign csr_ready  = 1'b1;
   assign rsp_valid  = frame_valid_ff;
   assign rsp_beat   = rsp_valid && !rsp_stall;
   assign last_b     = {1'b0, byte_cnt_ff} == (nb_eff - 3'd1);
   assign last_ch    = NC_W'(ch_cnt_ff) == (nc_eff - NC_W'(1));
   assign frame_done = rsp_beat && last_b && last_ch;
   assign s1_advance = !frame_valid_ff || frame_done;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_beat   = req_valid && !req_stall;

   // phase for this tick and table address
   always_comb begin
      phase_used = req_restart_phase ? 32'd0 : phase_ff;
      phase_in   = phase_used + (tone_en_ff ? phase_inc_ff : 32'd0);
      quad       = phase_used[31:30];
      pos        = phase_used[29 -: SINE_TABLE_BITS];
      if (quad[0]) begin
         rom_idx = (SINE_TABLE_BITS+1)'(TABLE_SIZE) - {1'b0, pos};
      end else begin
         rom_idx = {1'b0, pos};
      end
   end

   // scale the table entry by 2^s - 1 with a shift and subtract, then sign; zero while tone is off
   always_comb begin
      shamt = {nb_eff, 3'b000} - 6'd1;
      amp   = 32'((64'd1 << shamt) - 64'd1);
      prod  = ({32'b0, rom_q_ff} << shamt) - {32'b0, rom_q_ff};
      mag   = s1_full_ff ? amp : prod[62:31];
      if (!tone_en_ff) begin
         sample_new = 32'd0;
      end else if (s1_neg_ff) begin
         sample_new = 32'd0 - mag;
      end else begin
         sample_new = mag;
      end
   end

   // pipeline and serializer control
   always_comb begin
      s1_valid_in    = s1_valid_ff;
      frame_valid_in = frame_valid_ff;
      byte_cnt_in    = byte_cnt_ff;
      ch_cnt_in      = ch_cnt_ff;
      if (rsp_beat) begin
         if (last_b) begin
            byte_cnt_in = 2'd0;
            if (last_ch) begin
               ch_cnt_in      = '0;
               frame_valid_in = 1'b0;
            end else begin
               ch_cnt_in = ch_cnt_ff + CH_W'(1);
            end
         end else begin
            byte_cnt_in = byte_cnt_ff + 2'd1;
         end
      end
      if (s1_valid_ff && s1_advance) begin
         frame_valid_in = 1'b1;
         s1_valid_in    = 1'b0;
      end
      if (req_beat) begin
         s1_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff     <= 32'd0;
         tone_en_ff       <= 1'b0;
         sample_bytes_ff  <= SAMPLE_BYTES_RST;
         channel_count_ff <= CHANNEL_COUNT_RST;
         phase_ff         <= 32'd0;
         s1_valid_ff      <= 1'b0;
         frame_valid_ff   <= 1'b0;
         byte_cnt_ff      <= 2'd0;
         ch_cnt_ff        <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PHASE_INC:     phase_inc_ff     <= csr_wdata[31:0];
               REG_TONE_ENABLE:   tone_en_ff       <= csr_wdata[0];
               REG_SAMPLE_BYTES:  sample_bytes_ff  <= csr_wdata[2:0];
               REG_CHANNEL_COUNT: channel_count_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_beat) begin
            phase_ff <= phase_in;
         end
         s1_valid_ff    <= s1_valid_in;
         frame_valid_ff <= frame_valid_in;
         byte_cnt_ff    <= byte_cnt_in;
         ch_cnt_ff      <= ch_cnt_in;
      end
   end

   // sine table read, registered
   always_ff @(posedge clock) begin
      if (req_beat) begin
         rom_q_ff   <= SINE_ROM[rom_idx[SINE_TABLE_BITS-1:0]];
         s1_neg_ff  <= quad[1];
         s1_full_ff <= rom_idx[SINE_TABLE_BITS];
      end
   end

   // load the frame sample
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance) begin
         sample_ff <= sample_new;
      end
   end

   // drive the response beat
   assign rsp_out_byte      = 8'(sample_ff >> {byte_cnt_ff, 3'b000});
   assign rsp_channel_index = 3'(ch_cnt_ff);
   assign rsp_byte_index    = byte_cnt_ff;
   assign rsp_last_byte     = last_b && last_ch;

endmodule

// File: rtl/core/stsg_checker.sv
// ----------------------------------------------------------------------------
// stsg_checker: port-level checks for the sine tone sample generator
// Watches the request and response channels and checks frame sequencing.
// ----------------------------------------------------------------------------
module stsg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_channel_index,
   input logic [1:0] rsp_byte_index,
   input logic       rsp_last_byte
);

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_index) && $stable(rsp_channel_index)
         && $stable(rsp_last_byte))
      else $error("stalled response beat changed");

   // a frame drains without gaps once started
   a_frame_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_byte |=> rsp_valid)
      else $error("response frame broke off before its last byte");

   // advance byte, then channel, within a frame
   a_frame_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_byte |=>
         (rsp_byte_index == $past(rsp_byte_index) + 2'd1
            && rsp_channel_index == $past(rsp_channel_index))
         || (rsp_byte_index == 2'd0
            && rsp_channel_index == $past(rsp_channel_index) + 3'd1))
      else $error("response beat out of order");

   // request stalls only behind a pending response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // a new frame starts at the first byte of channel zero
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_byte ##1 rsp_valid |->
         rsp_byte_index == 2'd0 && rsp_channel_index == 3'd0)
      else $error("frame did not start at channel zero, byte zero");

endmodule

bind sine_tone_sample_generator_unit stsg_checker u_stsg_checker (.*);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: sine tone sample generator unit
// Drives sample ticks and register writes with random idle gaps on both
// sides, predicts every byte of each frame from its own sine table and
// phase accumulator, and checks the byte stream field by field in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import stsg_pkg::*;

   localparam int PERIOD        = 10;
   localparam int TABLE_BITS    = SINE_TABLE_BITS_DEF;
   localparam int TABLE_SIZE    = 1 << TABLE_BITS;
   localparam int CHANNELS_MAX  = MAX_CHANNELS_DEF;
   localparam int BYTES_MAX     = MAX_SAMPLE_BYTES_DEF;
   localparam int RANDOM_TICKS  = 200;
   localparam int IDLE_MAX      = 17;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int INDEX_TOP     = (1 << CSR_IDX_W) - 1;

   // first index that maps to no register
   localparam csr_idx_type REG_UNMAPPED = csr_idx_type'(REG_CHANNEL_COUNT + 1);

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] channel_index;
      logic [1:0] byte_index;
      logic       last_byte;
   } tone_byte_type;

   // -------------------------------------------------------------------------
   // Frame predictor and byte checker
   // -------------------------------------------------------------------------
   class tone_scoreboard;
      logic [31:0]   phase_step;
      logic          tone_on;
      logic [2:0]    bytes_reg;
      logic [3:0]    chans_reg;
      logic [31:0]   phase;
      logic [31:0]   quarter_rom [TABLE_SIZE];
      tone_byte_type expected_bytes [$];
      int            errors;

      function new();
         phase_step = '0;
         tone_on    = 1'b0;
         bytes_reg  = SAMPLE_BYTES_RST;
         chans_reg  = CHANNEL_COUNT_RST;
         phase      = '0;
         errors     = 0;
         for (int k = 0; k < TABLE_SIZE; k++) begin
            quarter_rom[k] = quarter_sine_q31(k);
         end
      endfunction

      // truncating Taylor series of sin(pi/2 * k / TABLE_SIZE) in Q1.31
      function logic [31:0] quarter_sine_q31(input int unsigned k);
         logic [63:0] x;
         logic [63:0] x2;
         logic [63:0] term;
         logic [63:0] acc;
         logic [63:0] n;
         x    = (HALF_PI_Q31 * {32'b0, k}) >> TABLE_BITS;
         x2   = (x * x) >> 31;
         term = x;
         acc  = x;
         n    = 64'd1;
         for (int i = 0; i < TAYLOR_TERMS; i++) begin
            term = ((term * x2) >> 31) / ((n + 64'd1) * (n + 64'd2));
            n    = n + 64'd2;
            if (i % 2 == 1) begin
               acc = acc + term;
            end else begin
               acc = acc - term;
            end
         end
         if (acc > 64'h7FFF_FFFF) begin
            acc = 64'h7FFF_FFFF;
         end
         return acc[31:0];
      endfunction

      function void write_reg(input csr_idx_type idx, input logic [31:0] data);
         case (idx)
            REG_PHASE_INC:     phase_step = data;
            REG_TONE_ENABLE:   tone_on    = data[0];
            REG_SAMPLE_BYTES:  bytes_reg  = data[2:0];
            REG_CHANNEL_COUNT: chans_reg  = data[3:0];
            default: ;
         endcase
      endfunction

      // signed sample at this phase, scaled to nb bytes, as a 32-bit pattern
      function logic [31:0] sine_sample(input logic [31:0] ph, input int nb);
         logic [63:0]           amp;
         logic [63:0]           mag;
         logic [1:0]            quad;
         logic [TABLE_BITS-1:0] pos;
         int unsigned           idx;
         amp  = (64'd1 << (8 * nb - 1)) - 64'd1;
         quad = ph[31:30];
         pos  = ph[29 -: TABLE_BITS];
         idx  = quad[0] ? TABLE_SIZE - pos : pos;
         if (idx >= TABLE_SIZE) begin
            mag = amp;
         end else begin
            mag = ({32'b0, quarter_rom[idx]} * amp) >> 31;
         end
         if (quad[1]) begin
            return 32'd0 - mag[31:0];
         end
         return mag[31:0];
      endfunction

      // queue the whole frame of one accepted tick, then advance the phase
      function void note_tick(input logic restart);
         int            nb;
         int            nc;
         logic [31:0]   sample;
         tone_byte_type item;
         nb = bytes_reg;
         nc = chans_reg;
         if (nb < 1) nb = 1;
         if (nb > BYTES_MAX) nb = BYTES_MAX;
         if (nc < 1) nc = 1;
         if (nc > CHANNELS_MAX) nc = CHANNELS_MAX;
         if (restart) phase = '0;
         sample = tone_on ? sine_sample(phase, nb) : 32'd0;
         for (int c = 0; c < nc; c++) begin
            for (int b = 0; b < nb; b++) begin
               item.out_byte      = sample[8*b +: 8];
               item.channel_index = 3'(c);
               item.byte_index    = 2'(b);
               item.last_byte     = (c == nc - 1 && b == nb - 1);
               expected_bytes.push_back(item);
            end
         end
         if (tone_on) phase = phase + phase_step;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      task report_mismatch(input string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_byte(input tone_byte_type got);
         tone_byte_type want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("byte beat with none expected: %h ch %0d pos %0d last %0b",
                                      got.out_byte, got.channel_index, got.byte_index,
                                      got.last_byte));
            return;
         end
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
         if (got.channel_index !== want.channel_index)
            report_mismatch($sformatf("channel_index %0d, want %0d",
                                      got.channel_index, want.channel_index));
         if (got.byte_index !== want.byte_index)
            report_mismatch($sformatf("byte_index %0d, want %0d",
                                      got.byte_index, want.byte_index));
         if (got.last_byte !== want.last_byte)
            report_mismatch($sformatf("last_byte %0b, want %0b", got.last_byte, want.last_byte));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_restart_phase;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [7:0]            rsp_out_byte;
   logic [2:0]            rsp_channel_index;
   logic [1:0]            rsp_byte_index;
   logic                  rsp_last_byte;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tone_scoreboard sb;
   bit             calm = 1'b0;   // no idling on either side while set

   sine_tone_sample_generator_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_restart_phase (req_restart_phase),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_channel_index (rsp_channel_index),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_last_byte     (rsp_last_byte),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic int next_gap();
      return calm ? 0 : $urandom_range(0, IDLE_MAX);
   endfunction

   // -------------------------------------------------------------------------
   // Driver tasks
   // -------------------------------------------------------------------------
   task automatic send_tick(input logic restart, input int gap);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_restart_phase = restart;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_tone(input logic [31:0] step, input logic on,
                           input logic [2:0] nbytes, input logic [3:0] nchans);
      csr_write(REG_PHASE_INC, step);
      csr_write(REG_TONE_ENABLE, {31'b0, on});
      csr_write(REG_SAMPLE_BYTES, {29'b0, nbytes});
      csr_write(REG_CHANNEL_COUNT, {28'b0, nchans});
   endtask

   // drop valid, wait for every queued byte, then let the pipeline settle
   task automatic drain_frames();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random register setting between phases, upper data bits as noise
   task automatic random_setting();
      logic [31:0] data;
      int          pick;
      pick = $urandom_range(0, 5);
      case (pick)
         0:       data = 32'd0;
         1:       data = 32'hFFFF_FFFF;
         2:       data = $urandom_range(0, 32'h00FF_FFFF);
         default: data = $urandom;
      endcase
      csr_write(REG_PHASE_INC, data);
      data    = $urandom;
      data[0] = ($urandom_range(0, 4) != 0);
      csr_write(REG_TONE_ENABLE, data);
      data = $urandom;
      if ($urandom_range(0, 9) < 8) data[2:0] = 3'($urandom_range(1, BYTES_MAX));
      csr_write(REG_SAMPLE_BYTES, data);
      data = $urandom;
      if ($urandom_range(0, 9) < 7) data[3:0] = 4'($urandom_range(1, 4));
      csr_write(REG_CHANNEL_COUNT, data);
      if ($urandom_range(0, 2) == 0)
         csr_write(csr_idx_type'($urandom_range(REG_UNMAPPED, INDEX_TOP)), $urandom);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: random stall ahead of each byte beat
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = next_gap();
         @(negedge clock);
         if (hold != 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: check byte beats, then queue frames of accepted ticks
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_byte({rsp_out_byte, rsp_channel_index, rsp_byte_index, rsp_last_byte});
         if (req_valid === 1'b1 && req_stall === 1'b0)
            sb.note_tick(req_restart_phase);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("sine_tone_sample_generator_unit test failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int sent;
      int batch;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_restart_phase = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      sb                = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults after reset: tone off, two bytes, one channel
      send_tick(1'b0, next_gap());
      send_tick(1'b1, next_gap());
      drain_frames();

      // quarter turns at widest frame: full-scale peak, zero crossings, trough
      set_tone(32'h4000_0000, 1'b1, 3'd4, 4'd8);
      send_tick(1'b1, next_gap());
      repeat (4) send_tick(1'b0, next_gap());
      drain_frames();

      // zero sizes act as one, largest step wraps the phase backward
      set_tone(32'hFFFF_FFFF, 1'b1, 3'd0, 4'd0);
      send_tick(1'b1, next_gap());
      repeat (2) send_tick(1'b0, next_gap());
      drain_frames();

      // oversized sizes clamp to the maximum, odd-quadrant table reads
      set_tone(32'h1000_0000, 1'b1, 3'd7, 4'd15);
      repeat (3) send_tick(1'b0, next_gap());
      drain_frames();

      // unmapped index ignored; tone off holds phase, restart still clears it
      csr_write(REG_UNMAPPED, 32'hFFFF_FFFF);
      set_tone(32'h0100_0000, 1'b0, 3'd1, 4'd3);
      send_tick(1'b0, next_gap());
      send_tick(1'b1, next_gap());
      drain_frames();
      csr_write(REG_TONE_ENABLE, 32'd1);
      csr_write(REG_SAMPLE_BYTES, 32'd3);
      csr_write(REG_CHANNEL_COUNT, 32'd2);
      send_tick(1'b0, next_gap());
      send_tick(1'b0, next_gap());
      send_tick(1'b1, next_gap());
      send_tick(1'b0, next_gap());
      drain_frames();

      // random phases, some with no idling at all
      sent = 0;
      while (sent < RANDOM_TICKS) begin
         random_setting();
         calm  = ($urandom_range(0, 3) == 0);
         batch = $urandom_range(12, 28);
         repeat (batch) send_tick($urandom_range(0, 7) == 0, next_gap());
         sent += batch;
         drain_frames();
         calm = 1'b0;
      end

      if (sb.errors == 0) begin
         $display("sine_tone_sample_generator_unit test passed");
      end else begin
         $display("sine_tone_sample_generator_unit test failed");
      end
      $finish;
   end

endmodule
